// ----- rtl/core/oop_pkg.sv -----
// Package for the octahedron orientation point block.
// Field widths, fixed-point constants, register indexes and the classified item type.
// No dependencies.
`default_nettype none

package oop_pkg;

    localparam int COORD_W  = 8;
    localparam int MULT_W   = 5;
    localparam int ANGLE_W  = 17;
    localparam int WEIGHT_W = 32;

    localparam int MAX_GRID    = 255;
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [7:0] CFG_GRID_SIZE   = 8'd0;
    localparam logic [7:0] CFG_INTERPOLATE = 8'd1;

    // 2^51 / (3*pi), rounded
    localparam logic [47:0] WEIGHT_C = 48'd238923380800944;
    localparam logic [ANGLE_W-1:0] Q16_ONE = 17'd65536;

    // angle lane: quotient of a*2^34/b, then its integer root
    localparam int RATIO_W  = 18;
    localparam int QUO_W    = 35;
    localparam int ROOT_W   = 18;
    localparam int LANE_LAT = QUO_W + ROOT_W + 1;

    typedef struct packed {
        logic               ok;
        logic               az;
        logic [COORD_W-1:0] n;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [MULT_W-1:0]  m;
    } t_item;

endpackage

`default_nettype wire

// ----- rtl/core/oop_front.sv -----
// Front stage: accepts grid points, checks them against the face and
// classifies edges and vertices. Uses oop_pkg.
`default_nettype none

module oop_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [oop_pkg::COORD_W-1:0]   i_y_step,
    input  wire logic [oop_pkg::COORD_W-1:0]   i_z_step,
    input  wire logic [oop_pkg::COORD_W-1:0]   i_grid_size,
    input  wire logic                          i_interpolate,
    output logic                               o_push,
    output oop_pkg::t_item                     o_item,
    input  wire logic                          i_full
);

    localparam logic [9:0] MAX_N = 10'(oop_pkg::MAX_GRID);
    localparam logic [oop_pkg::MULT_W-1:0] M_PLAIN  = 5'd4;
    localparam logic [oop_pkg::MULT_W-1:0] M_VERTEX = 5'd6;
    localparam logic [oop_pkg::MULT_W-1:0] M_EDGE   = 5'd12;
    localparam logic [oop_pkg::MULT_W-1:0] M_FACE   = 5'd24;

    logic [oop_pkg::COORD_W-1:0] w_n;
    logic [oop_pkg::COORD_W:0]   w_sum;
    logic [oop_pkg::COORD_W-1:0] w_x;
    logic                        w_ok;
    logic [1:0]                  w_zeros;
    logic                        w_take;
    oop_pkg::t_item              n_item;
    oop_pkg::t_item              r_item;
    logic                        r_valid;

    always_comb begin
        w_n     = ({2'b00, i_grid_size} > MAX_N) ? MAX_N[7:0] : i_grid_size;
        w_sum   = {1'b0, i_y_step} + {1'b0, i_z_step};
        w_ok    = (w_n != '0) && (w_sum <= {1'b0, w_n});
        w_x     = w_n - w_sum[oop_pkg::COORD_W-1:0];
        w_zeros = 2'(w_x == '0) + 2'(i_y_step == '0) + 2'(i_z_step == '0);

        n_item.ok = w_ok;
        n_item.az = w_ok && (w_x == '0) && (i_y_step == '0);
        n_item.n  = w_n;
        // points off the face run through with a harmless geometry
        n_item.x  = w_ok ? w_x : 8'd1;
        n_item.y  = w_ok ? i_y_step : '0;
        n_item.z  = w_ok ? i_z_step : '0;
        if (i_interpolate) begin
            n_item.m = M_PLAIN;
        end else if (w_zeros >= 2'd2) begin
            n_item.m = M_VERTEX;
        end else if (w_zeros == 2'd1) begin
            n_item.m = M_EDGE;
        end else begin
            n_item.m = M_FACE;
        end
    end

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign w_take  = i_valid && !o_stall;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/oop_queue.sv -----
// Short item queue between the front stage and the arithmetic pipeline.
// Uses oop_pkg for the item type.
`default_nettype none

module oop_queue #(
    parameter int DEPTH = oop_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire oop_pkg::t_item i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output oop_pkg::t_item      o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    oop_pkg::t_item  r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/oop_lane.sv -----
// Angle lane: round(65536*sqrt(num/den)) with num <= den, as a pipelined
// restoring divide followed by a pipelined integer root. Uses oop_pkg.
`default_nettype none

module oop_lane (
    input  wire logic                          i_clk,
    input  wire logic                          i_adv,
    input  wire logic [oop_pkg::RATIO_W-1:0]   i_num,
    input  wire logic [oop_pkg::RATIO_W-1:0]   i_den,
    output logic      [oop_pkg::ANGLE_W-1:0]   o_ratio
);

    localparam int DW = oop_pkg::RATIO_W;
    localparam int QW = oop_pkg::QUO_W;
    localparam int RW = oop_pkg::ROOT_W;
    localparam int SW = 2 * RW;

    logic [DW-1:0]             r_rem  [QW];
    logic [DW-1:0]             r_den  [QW];
    logic [QW-1:0]             r_quo  [QW];
    logic [SW-1:0]             r_sv   [RW];
    logic [SW-1:0]             r_sres [RW];
    logic [oop_pkg::ANGLE_W-1:0] r_ratio;
    logic [RW:0]               w_round;

    // one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [DW:0]   w_trial;
        logic [DW-1:0] w_den;
        logic [QW-1:0] w_quo;
        logic          w_bit;
        if (k == 0) begin : g_first
            assign w_trial = {1'b0, i_num};
            assign w_den   = i_den;
            assign w_quo   = '0;
        end else begin : g_next
            assign w_trial = {r_rem[k-1], 1'b0};
            assign w_den   = r_den[k-1];
            assign w_quo   = r_quo[k-1];
        end
        assign w_bit = (w_trial >= {1'b0, w_den});
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k] <= w_bit ? DW'(w_trial - {1'b0, w_den}) : w_trial[DW-1:0];
                r_den[k] <= w_den;
                r_quo[k] <= {w_quo[QW-2:0], w_bit};
            end
        end
    end

    // one root bit per stage
    for (genvar j = 0; j < RW; j++) begin : g_root
        localparam logic [SW-1:0] BIT = SW'(1) << (2 * (RW - 1 - j));
        logic [SW-1:0] w_v;
        logic [SW-1:0] w_res;
        logic [SW-1:0] w_try;
        logic          w_fit;
        if (j == 0) begin : g_first
            assign w_v   = SW'(r_quo[QW-1]);
            assign w_res = '0;
        end else begin : g_next
            assign w_v   = r_sv[j-1];
            assign w_res = r_sres[j-1];
        end
        assign w_try = w_res + BIT;
        assign w_fit = (w_v >= w_try);
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_sv[j]   <= w_fit ? w_v - w_try : w_v;
                r_sres[j] <= w_fit ? (w_res >> 1) + BIT : (w_res >> 1);
            end
        end
    end

    // largest L with (2L-1)^2 <= quotient
    assign w_round = {1'b0, r_sres[RW-1][RW-1:0]} + (RW + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ratio <= w_round[RW-1:1];
        end
    end

    assign o_ratio = r_ratio;

endmodule

`default_nettype wire

// ----- rtl/core/oop_back.sv -----
// Arithmetic pipeline: squares, four angle lanes and the weight path
// (root, products, saturating divide). Uses oop_pkg and oop_lane.
`default_nettype none

module oop_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_empty,
    input  wire oop_pkg::t_item                 i_item,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [oop_pkg::ANGLE_W-1:0]         o_az_cos,
    output logic [oop_pkg::ANGLE_W-1:0]         o_sin_alpha,
    output logic [oop_pkg::ANGLE_W-1:0]         o_polar_cos,
    output logic [oop_pkg::ANGLE_W-1:0]         o_polar_sin,
    output logic [oop_pkg::WEIGHT_W-1:0]        o_weight,
    output logic                                o_point_valid
);

    localparam int AW      = oop_pkg::ANGLE_W;
    localparam int DW      = oop_pkg::RATIO_W;
    localparam int WSQ     = 30;
    localparam int WVW     = 2 * WSQ + 1;
    localparam int SHIFT   = 42;
    localparam int DDW     = 48;
    localparam int NUMW    = 61;
    localparam int DIVW    = oop_pkg::WEIGHT_W;
    localparam int ANG_END = 1 + oop_pkg::LANE_LAT;
    localparam int PRE     = 1 + WSQ + 2;
    localparam int LAST    = PRE + DIVW;
    localparam int ADLY    = LAST - ANG_END;

    logic              w_adv;
    logic [LAST:0]     r_v;
    logic [1:0]        r_flag [LAST+1];

    logic [15:0]       r_xx, r_yy, r_zz;
    logic [7:0]        r_n;
    logic [4:0]        r_m;
    logic [15:0]       r_xx1, r_yy1, r_zz1;
    logic [DW-2:0]     r_sxy;
    logic [DW-1:0]     r_r2;
    logic [DW-1:0]     r_da;
    logic [12:0]       r_nm;

    logic [AW-1:0]     w_ca, w_sa, w_cb, w_sb;
    logic [4*AW-1:0]   r_adly [ADLY];

    logic [WVW-1:0]    r_wv   [WSQ];
    logic [WVW-1:0]    r_wres [WSQ];
    logic [DW-1:0]     r_wr2  [WSQ];
    logic [12:0]       r_wnm  [WSQ];

    logic [DDW-1:0]    r_d;
    logic [NUMW-1:0]   r_num;
    logic [NUMW:0]     w_nd;
    logic [29:0]       r_h;
    logic [31:0]       r_lo;
    logic [DDW-1:0]    r_pd;
    logic              r_psat;

    logic [DDW-1:0]    r_dh   [DIVW];
    logic [31:0]       r_dlo  [DIVW];
    logic [DDW-1:0]    r_dd   [DIVW];
    logic [DIVW-1:0]   r_dq   [DIVW];
    logic              r_dsat [DIVW];

    logic              r_out_valid;
    logic [AW-1:0]     r_ca, r_sa, r_cb, r_sb;
    logic [DIVW-1:0]   r_w;
    logic              r_pv;
    logic              w_ok, w_az;
    logic [4*AW-1:0]   w_ang;

    assign w_adv = !r_out_valid || !i_stall;
    assign o_pop = w_adv && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v         <= {r_v[LAST-1:0], o_pop};
            r_out_valid <= r_v[LAST];
        end
    end

    for (genvar f = 0; f <= LAST; f++) begin : g_flag
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (f == 0) begin
                    r_flag[f] <= {i_item.ok, i_item.az};
                end else begin
                    r_flag[f] <= r_flag[(f == 0) ? 0 : f-1];
                end
            end
        end
    end

    // squares, then sums
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xx  <= i_item.x * i_item.x;
            r_yy  <= i_item.y * i_item.y;
            r_zz  <= i_item.z * i_item.z;
            r_n   <= i_item.n;
            r_m   <= i_item.m;
            r_xx1 <= r_xx;
            r_yy1 <= r_yy;
            r_zz1 <= r_zz;
            r_sxy <= {1'b0, r_xx} + {1'b0, r_yy};
            r_r2  <= {2'b00, r_xx} + {2'b00, r_yy} + {2'b00, r_zz};
            r_da  <= (r_xx == '0 && r_yy == '0) ? DW'(1) : {2'b00, r_xx} + {2'b00, r_yy};
            r_nm  <= r_n * r_m;
        end
    end

    oop_lane u_az_cos (
        .i_clk(i_clk), .i_adv(w_adv), .i_num(DW'(r_xx1)), .i_den(r_da), .o_ratio(w_ca)
    );
    oop_lane u_sin_alpha (
        .i_clk(i_clk), .i_adv(w_adv), .i_num(DW'(r_yy1)), .i_den(r_da), .o_ratio(w_sa)
    );
    oop_lane u_polar_cos (
        .i_clk(i_clk), .i_adv(w_adv), .i_num(DW'(r_zz1)), .i_den(r_r2), .o_ratio(w_cb)
    );
    oop_lane u_polar_sin (
        .i_clk(i_clk), .i_adv(w_adv), .i_num(DW'(r_sxy)), .i_den(r_r2), .o_ratio(w_sb)
    );

    for (genvar a = 0; a < ADLY; a++) begin : g_adly
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (a == 0) begin
                    r_adly[a] <= {w_ca, w_sa, w_cb, w_sb};
                end else begin
                    r_adly[a] <= r_adly[(a == 0) ? 0 : a-1];
                end
            end
        end
    end

    // weight root s = isqrt(r2 * 2^42), one bit per stage
    for (genvar j = 0; j < WSQ; j++) begin : g_wroot
        localparam logic [WVW-1:0] BIT = WVW'(1) << (2 * (WSQ - 1 - j));
        logic [WVW-1:0] w_v;
        logic [WVW-1:0] w_res;
        logic [WVW-1:0] w_try;
        logic [DW-1:0]  w_r2;
        logic [12:0]    w_nm;
        logic           w_fit;
        if (j == 0) begin : g_first
            assign w_v   = WVW'({r_r2, SHIFT'(0)});
            assign w_res = '0;
            assign w_r2  = r_r2;
            assign w_nm  = r_nm;
        end else begin : g_next
            assign w_v   = r_wv[j-1];
            assign w_res = r_wres[j-1];
            assign w_r2  = r_wr2[j-1];
            assign w_nm  = r_wnm[j-1];
        end
        assign w_try = w_res + BIT;
        assign w_fit = (w_v >= w_try);
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_wv[j]   <= w_fit ? w_v - w_try : w_v;
                r_wres[j] <= w_fit ? (w_res >> 1) + BIT : (w_res >> 1);
                r_wr2[j]  <= w_r2;
                r_wnm[j]  <= w_nm;
            end
        end
    end

    // D = r2 * s, N = n * m * C, then N + D/2 split for the divide
    assign w_nd = {1'b0, r_num} + (NUMW + 1)'(r_d >> 1);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d    <= DDW'(r_wr2[WSQ-1]) * DDW'(r_wres[WSQ-1][WSQ-1:0]);
            r_num  <= NUMW'(r_wnm[WSQ-1]) * NUMW'(oop_pkg::WEIGHT_C);
            r_h    <= w_nd[NUMW:32];
            r_lo   <= w_nd[31:0];
            r_pd   <= r_d;
            r_psat <= (DDW'(w_nd[NUMW:32]) >= r_d);
        end
    end

    for (genvar k = 0; k < DIVW; k++) begin : g_wdiv
        logic [DDW-1:0]  w_h;
        logic [31:0]     w_lo;
        logic [DDW-1:0]  w_d;
        logic [DIVW-1:0] w_q;
        logic            w_sat;
        logic [DDW:0]    w_trial;
        logic            w_bit;
        if (k == 0) begin : g_first
            assign w_h   = DDW'(r_h);
            assign w_lo  = r_lo;
            assign w_d   = r_pd;
            assign w_q   = '0;
            assign w_sat = r_psat;
        end else begin : g_next
            assign w_h   = r_dh[k-1];
            assign w_lo  = r_dlo[k-1];
            assign w_d   = r_dd[k-1];
            assign w_q   = r_dq[k-1];
            assign w_sat = r_dsat[k-1];
        end
        assign w_trial = {w_h, w_lo[31]};
        assign w_bit   = (w_trial >= {1'b0, w_d});
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dh[k]   <= w_bit ? DDW'(w_trial - {1'b0, w_d}) : w_trial[DDW-1:0];
                r_dlo[k]  <= {w_lo[30:0], 1'b0};
                r_dd[k]   <= w_d;
                r_dq[k]   <= {w_q[DIVW-2:0], w_bit};
                r_dsat[k] <= w_sat;
            end
        end
    end

    assign w_ok  = r_flag[LAST][1];
    assign w_az  = r_flag[LAST][0];
    assign w_ang = r_adly[ADLY-1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ca <= (w_ok && !w_az) ? w_ang[4*AW-1:3*AW] : '0;
            r_sa <= (w_ok && !w_az) ? w_ang[3*AW-1:2*AW] : '0;
            r_cb <= w_ok ? w_ang[2*AW-1:AW] : '0;
            r_sb <= w_ok ? w_ang[AW-1:0] : '0;
            r_w  <= !w_ok ? '0 : (r_dsat[DIVW-1] ? '1 : r_dq[DIVW-1]);
            r_pv <= w_ok;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_az_cos      = r_ca;
    assign o_sin_alpha   = r_sa;
    assign o_polar_cos   = r_cb;
    assign o_polar_sin   = r_sb;
    assign o_weight      = r_w;
    assign o_point_valid = r_pv;

endmodule

`default_nettype wire

// ----- rtl/core/octahedron_orientation_point_top.sv -----
// Top level of the octahedron orientation point block: configuration
// registers, front stage, item queue and arithmetic pipeline.
// Uses oop_pkg, oop_front, oop_queue, oop_back.
//
// One grid point (y_step, z_step) of the face x+y+z=grid_size goes in per
// clock and one result comes out per clock while neither side stalls. An
// item passes the front register and the queue, then the pipeline stages
// set by the weight path (30-step root, two product stages, 32-step
// saturating divide); the angle lanes (35-step quotient, 18-step root) are
// padded to match. The 4-entry queue absorbs stalls on the result side
// before the input stalls. Configuration writes are always accepted and
// must be made with the block idle.
`default_nettype none

module octahedron_orientation_point_top #(
    parameter int QUEUE_DEPTH = oop_pkg::QUEUE_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [7:0]                  i_cfg_index,
    input  wire logic [7:0]                  i_cfg_data,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [oop_pkg::COORD_W-1:0] i_y_step,
    input  wire logic [oop_pkg::COORD_W-1:0] i_z_step,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [oop_pkg::ANGLE_W-1:0]      o_az_cos,
    output logic [oop_pkg::ANGLE_W-1:0]      o_sin_alpha,
    output logic [oop_pkg::ANGLE_W-1:0]      o_polar_cos,
    output logic [oop_pkg::ANGLE_W-1:0]      o_polar_sin,
    output logic [oop_pkg::WEIGHT_W-1:0]     o_weight,
    output logic                             o_point_valid
);

    logic [7:0]     r_grid_size;
    logic           r_interpolate;
    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_empty;
    oop_pkg::t_item w_front_item;
    oop_pkg::t_item w_queue_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size   <= 8'd25;
            r_interpolate <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                oop_pkg::CFG_GRID_SIZE:   r_grid_size   <= i_cfg_data;
                oop_pkg::CFG_INTERPOLATE: r_interpolate <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    oop_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_y_step      (i_y_step),
        .i_z_step      (i_z_step),
        .i_grid_size   (r_grid_size),
        .i_interpolate (r_interpolate),
        .o_push        (w_push),
        .o_item        (w_front_item),
        .i_full        (w_full)
    );

    oop_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_queue_item)
    );

    oop_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_item        (w_queue_item),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_az_cos      (o_az_cos),
        .o_sin_alpha   (o_sin_alpha),
        .o_polar_cos   (o_polar_cos),
        .o_polar_sin   (o_polar_sin),
        .o_weight      (o_weight),
        .o_point_valid (o_point_valid)
    );

    a_off_face_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_point_valid |-> o_az_cos == '0 && o_sin_alpha == '0 &&
            o_polar_cos == '0 && o_polar_sin == '0 && o_weight == '0)
        else $error("off-face item with nonzero fields");

    a_z_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_point_valid && o_az_cos == '0 && o_sin_alpha == '0 |->
            o_polar_cos == oop_pkg::Q16_ONE && o_polar_sin == '0)
        else $error("zero azimuth off the z vertex");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_polar_cos <= oop_pkg::Q16_ONE && o_polar_sin <= oop_pkg::Q16_ONE &&
            o_az_cos <= oop_pkg::Q16_ONE && o_sin_alpha <= oop_pkg::Q16_ONE)
        else $error("angle above one");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Testbench for octahedron_orientation_point_top: directed and random grid points,
// checked field by field against an integer-exact predictor. Uses oop_pkg.
`default_nettype none

module testbench;

    localparam int CFG_NONE = 2;
    localparam longint unsigned WEIGHT_K = 64'd238923380800944;

    typedef struct packed {
        logic [oop_pkg::ANGLE_W-1:0]  cos_a;
        logic [oop_pkg::ANGLE_W-1:0]  sin_a;
        logic [oop_pkg::ANGLE_W-1:0]  cos_b;
        logic [oop_pkg::ANGLE_W-1:0]  sin_b;
        logic [oop_pkg::WEIGHT_W-1:0] wt;
        logic                         pv;
    } t_point;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [7:0] i_cfg_index = 0;
    logic [7:0] i_cfg_data = 0;
    logic i_valid = 0;
    logic o_stall;
    logic [oop_pkg::COORD_W-1:0] i_y_step = 0;
    logic [oop_pkg::COORD_W-1:0] i_z_step = 0;
    logic o_valid;
    logic i_stall = 0;
    logic [oop_pkg::ANGLE_W-1:0] o_az_cos, o_sin_alpha, o_polar_cos, o_polar_sin;
    logic [oop_pkg::WEIGHT_W-1:0] o_weight;
    logic o_point_valid;

    octahedron_orientation_point_top u_top (.*);

    t_point expected_points[$];
    int errors = 0;
    int results_seen = 0;
    int points_sent = 0;
    int grid_n = 25;
    bit interp_on = 1;
    bit hold_off = 0;
    bit sink_random = 1;

    initial forever #5 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // round(65536*sqrt(a/b)), tie up
    function automatic logic [oop_pkg::ANGLE_W-1:0] root_ratio(longint unsigned a,
                                                               longint unsigned b);
        longint unsigned lo, hi, mid, odd, rhs;
        lo = 0;
        hi = 65536;
        rhs = a << 34;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            odd = 2 * mid - 1;
            if (odd * odd * b <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo[oop_pkg::ANGLE_W-1:0];
    endfunction

    function automatic t_point predict_point(int yi, int zj);
        t_point p;
        longint unsigned x, sxy2, r2, s, d, num, w, m;
        int zeros;
        p = '0;
        if (grid_n == 0 || yi + zj > grid_n) return p;
        x = grid_n - yi - zj;
        sxy2 = x * x + yi * yi;
        r2 = sxy2 + zj * zj;
        if (sxy2 != 0) begin
            p.cos_a = root_ratio(x * x, sxy2);
            p.sin_a = root_ratio(yi * yi, sxy2);
        end
        p.cos_b = root_ratio(zj * zj, r2);
        p.sin_b = root_ratio(sxy2, r2);
        zeros = (x == 0) + (yi == 0) + (zj == 0);
        if (interp_on) m = 4;
        else if (zeros >= 2) m = 6;
        else if (zeros == 1) m = 12;
        else m = 24;
        s = int_root(r2 << 42);
        d = r2 * s;
        num = grid_n * m * WEIGHT_K;
        w = (num + (d >> 1)) / d;
        if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
        p.wt = w[31:0];
        p.pv = 1;
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_point e;
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                e = expected_points.pop_front();
                if (o_az_cos !== e.cos_a) report_mismatch("az_cos", o_az_cos, e.cos_a);
                if (o_sin_alpha !== e.sin_a) report_mismatch("sin_alpha", o_sin_alpha, e.sin_a);
                if (o_polar_cos !== e.cos_b)
                    report_mismatch("polar_cos", o_polar_cos, e.cos_b);
                if (o_polar_sin !== e.sin_b)
                    report_mismatch("polar_sin", o_polar_sin, e.sin_b);
                if (o_weight !== e.wt) report_mismatch("weight", o_weight, e.wt);
                if (o_point_valid !== e.pv)
                    report_mismatch("point_valid", o_point_valid, e.pv);
            end
            results_seen++;
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (hold_off) i_stall <= 1;
        else if (!sink_random) i_stall <= 0;
        else if ($urandom_range(0, 99) < 3) i_stall <= 1;
        else if (i_stall && $urandom_range(0, 99) < 30) i_stall <= 1;
        else i_stall <= ($urandom_range(0, 99) < 15);
    end

    task automatic send_point(int yi, int zj);
        int gap;
        i_valid <= 1;
        i_y_step <= yi[7:0];
        i_z_step <= zj[7:0];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_points.push_back(predict_point(yi, zj));
        points_sent++;
        @(negedge i_clk);
        gap = 0;
        if (sink_random) begin
            if ($urandom_range(0, 99) < 3) gap = $urandom_range(10, 40);
            else if ($urandom_range(0, 99) < 25) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain;
        int guard;
        i_valid <= 0;
        guard = 0;
        while (expected_points.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_reg(int idx, int val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx[7:0];
        i_cfg_data <= val[7:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == int'(oop_pkg::CFG_GRID_SIZE)) grid_n = val;
        else if (idx == int'(oop_pkg::CFG_INTERPOLATE)) interp_on = val[0];
        @(negedge i_clk);
        i_cfg_valid <= 0;
        @(negedge i_clk);
    endtask

    task automatic test_directed;
        send_point(0, 0);
        send_point(25, 0);
        send_point(0, 25);
        send_point(10, 10);
        send_point(20, 6);
        send_point(255, 255);
        send_point(13, 0);
        send_point(0, 13);
        send_point(12, 13);
        drain();
        write_reg(oop_pkg::CFG_INTERPOLATE, 0);
        send_point(0, 0);
        send_point(25, 0);
        send_point(0, 25);
        send_point(5, 0);
        send_point(0, 7);
        send_point(5, 20);
        send_point(8, 9);
        drain();
        write_reg(oop_pkg::CFG_GRID_SIZE, 255);
        send_point(0, 0);
        send_point(255, 0);
        send_point(0, 255);
        send_point(85, 85);
        send_point(128, 128);
        drain();
        write_reg(oop_pkg::CFG_GRID_SIZE, 0);
        send_point(0, 0);
        send_point(170, 85);
        drain();
        write_reg(oop_pkg::CFG_GRID_SIZE, 1);
        write_reg(CFG_NONE, 77);
        send_point(0, 0);
        send_point(1, 0);
        send_point(0, 1);
        drain();
    endtask

    task automatic test_random(int count);
        int yi, zj;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 85) begin
                yi = $urandom_range(0, grid_n);
                zj = $urandom_range(0, grid_n - yi);
            end else begin
                yi = $urandom_range(0, 255);
                zj = $urandom_range(0, 255);
            end
            send_point(yi, zj);
        end
        drain();
    endtask

    task automatic test_backpressure;
        fork
            begin
                hold_off = 1;
                repeat (200) @(negedge i_clk);
                hold_off = 0;
            end
            begin
                sink_random = 0;
                for (int k = 0; k < 120; k++) send_point(k % 20, (3 * k) % 15);
                sink_random = 1;
            end
        join
        drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        test_directed();
        write_reg(oop_pkg::CFG_GRID_SIZE, 25);
        write_reg(oop_pkg::CFG_INTERPOLATE, 1);
        test_random(300);
        write_reg(oop_pkg::CFG_INTERPOLATE, 0);
        test_random(300);
        write_reg(oop_pkg::CFG_GRID_SIZE, 255);
        test_random(300);
        write_reg(oop_pkg::CFG_INTERPOLATE, 1);
        test_random(300);
        write_reg(oop_pkg::CFG_GRID_SIZE, 1);
        test_random(100);
        write_reg(oop_pkg::CFG_GRID_SIZE, 7);
        write_reg(oop_pkg::CFG_INTERPOLATE, 0);
        test_random(200);
        write_reg(oop_pkg::CFG_GRID_SIZE, $urandom_range(2, 254));
        test_random(200);
        write_reg(oop_pkg::CFG_GRID_SIZE, 30);
        test_backpressure();
        $display("covered %0d points, %0d results, grid sizes 0..255, both weight modes",
                 points_sent, results_seen);
        if (errors == 0 && expected_points.size() == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule

`default_nettype wire
